/* src/sorted_set_member_insert_delete_top_assert.svh */
// Assertion macros for the sorted set block.
`ifndef SORTED_SET_MEMBER_INSERT_DELETE_TOP_ASSERT_SVH
`define SORTED_SET_MEMBER_INSERT_DELETE_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define SS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define SS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

/* src/ssmid_pkg.sv */
// ----------------------------------------------------------------------------
// ssmid_pkg
// Shared types and codes for the sorted set block.
// ----------------------------------------------------------------------------
package ssmid_pkg;

    localparam logic [1:0] OP_QUERY  = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_SHIFT,
        ST_RESULT
    } state_t;

endpackage

/* src/ssmid_in_if.sv */
// ----------------------------------------------------------------------------
// ssmid_in_if
// Command channel: opcode and value.
// ----------------------------------------------------------------------------
interface ssmid_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         opcode;
    logic signed [31:0] key_value;

    modport source (output valid, output opcode, output key_value, input ready);
    modport sink   (input valid, input opcode, input key_value, output ready);
endinterface

/* src/ssmid_out_if.sv */
// ----------------------------------------------------------------------------
// ssmid_out_if
// Result channel: success, full flag and count.
// ----------------------------------------------------------------------------
interface ssmid_out_if;
    logic       valid;
    logic       ready;
    logic       success;
    logic       full_res;
    logic [8:0] entry_count;

    modport source (output valid, output success, output full_res, output entry_count,
                    input ready);
    modport sink   (input valid, input success, input full_res, input entry_count,
                    output ready);
endinterface

/* src/sorted_set_member_insert_delete_top.sv */
// ----------------------------------------------------------------------------
// sorted_set_member_insert_delete_top
// Sorted set of distinct signed values held in one RAM, scanned and shifted.
// ----------------------------------------------------------------------------
// channel | dir | word
// cmd     | in  | opcode[1:0], key_value[31:0] signed
// res     | out | success, full_res, entry_count[8:0]
//
// One item at a time. Scan reads one entry a cycle until the first entry
// not below the key or the end of the store. A decide state follows;
// insert or delete then shifts the entries from pos on by one place
// (read then write pipelined), and the item then ends in ST_RESULT.
// Reset clears count, control and the result register; RAM is not cleared.
// The result sits in an output register, so the next command is taken while
// it waits; a later result waits in ST_RESULT until that register frees.
`include "sorted_set_member_insert_delete_top_assert.svh"

module sorted_set_member_insert_delete_top #(
    parameter int CAPACITY = 256
) (
    input  logic         clk,
    input  logic         rst_n,
    ssmid_in_if.sink     cmd,
    ssmid_out_if.source  res
);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    ssmid_pkg::state_t state_reg, state_next;

    logic [1:0]         op_reg, op_next;
    logic signed [31:0] key_reg, key_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [CW-1:0]      pos_reg, pos_next;   // scan / shift index
    logic [CW-1:0]      rd_reg, rd_next;     // index of outstanding read
    logic               rdv_reg, rdv_next;
    logic               ok_reg, ok_next;
    logic               full_reg, full_next;
    logic signed [31:0] carry_reg, carry_next; // insert ripple value

    // result register
    logic               out_valid_reg, out_valid_next;
    logic               out_ok_reg, out_ok_next;
    logic               out_full_reg, out_full_next;
    logic [8:0]         out_cnt_reg, out_cnt_next;
    logic               out_load;

    logic               we;
    logic [AW-1:0]      waddr, raddr;
    logic [31:0]        wdata, rdata;
    logic signed [31:0] rd_s;

    ssmid_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    assign rd_s = signed'(rdata);

    // finished item moves into the result register once it is free
    assign out_load = (state_reg == ssmid_pkg::ST_RESULT) && (!out_valid_reg || res.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ssmid_pkg::ST_IDLE;
            cnt_reg       <= '0;
            rdv_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            out_ok_reg    <= 1'b0;
            out_full_reg  <= 1'b0;
            out_cnt_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rdv_reg       <= rdv_next;
            out_valid_reg <= out_valid_next;
            out_ok_reg    <= out_ok_next;
            out_full_reg  <= out_full_next;
            out_cnt_reg   <= out_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        key_reg   <= key_next;
        pos_reg   <= pos_next;
        rd_reg    <= rd_next;
        ok_reg    <= ok_next;
        full_reg  <= full_next;
        carry_reg <= carry_next;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ssmid_pkg::ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    state_next = ssmid_pkg::ST_SCAN;
                end
            end
            ssmid_pkg::ST_SCAN:
            begin
                if (rdv_reg && rd_s >= key_reg)
                begin
                    state_next = ssmid_pkg::ST_DECIDE;
                end
                else if (pos_reg == cnt_reg && !rdv_reg)
                begin
                    state_next = ssmid_pkg::ST_DECIDE;
                end
            end
            ssmid_pkg::ST_DECIDE:
            begin
                state_next = ssmid_pkg::ST_RESULT;
                if (op_reg == ssmid_pkg::OP_INSERT && !(rdv_reg && rd_s == key_reg)
                    && cnt_reg != CW'(CAPACITY))
                begin
                    state_next = ssmid_pkg::ST_SHIFT;
                end
                if (op_reg != ssmid_pkg::OP_QUERY && op_reg != ssmid_pkg::OP_INSERT
                    && rdv_reg && rd_s == key_reg)
                begin
                    state_next = ssmid_pkg::ST_SHIFT;
                end
            end
            ssmid_pkg::ST_SHIFT:
            begin
                if (op_reg == ssmid_pkg::OP_INSERT)
                begin
                    if (pos_reg == cnt_reg)
                    begin
                        state_next = ssmid_pkg::ST_RESULT;
                    end
                end
                else if (pos_reg + CW'(1) >= cnt_reg)
                begin
                    state_next = ssmid_pkg::ST_RESULT;
                end
            end
            ssmid_pkg::ST_RESULT:
            begin
                if (out_load)
                begin
                    state_next = ssmid_pkg::ST_IDLE;
                end
            end
            default: state_next = ssmid_pkg::ST_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        op_next    = op_reg;
        key_next   = key_reg;
        cnt_next   = cnt_reg;
        pos_next   = pos_reg;
        rd_next    = rd_reg;
        rdv_next   = 1'b0;
        ok_next    = ok_reg;
        full_next  = full_reg;
        carry_next = carry_reg;
        we         = 1'b0;
        waddr      = pos_reg[AW-1:0];
        wdata      = 32'(carry_reg);
        raddr      = pos_reg[AW-1:0];
        cmd.ready  = (state_reg == ssmid_pkg::ST_IDLE);
        unique case (state_reg)
            ssmid_pkg::ST_IDLE:
            begin
                op_next   = cmd.opcode;
                key_next  = cmd.key_value;
                pos_next  = '0;
                ok_next   = 1'b0;
                full_next = 1'b0;
            end
            ssmid_pkg::ST_SCAN:
            begin
                // issue read of pos while checking previous read
                if (rdv_reg && rd_s >= key_reg)
                begin
                    rdv_next = 1'b1;   // keep match data visible via re-read below
                    pos_next = rd_reg;
                    raddr    = rd_reg[AW-1:0];
                end
                else if (pos_reg < cnt_reg)
                begin
                    rdv_next = 1'b1;
                    rd_next  = pos_reg;
                    pos_next = pos_reg + CW'(1);
                end
                else if (rdv_reg)
                begin
                    pos_next = cnt_reg;
                end
            end
            ssmid_pkg::ST_DECIDE:
            begin
                // rdata = entry at pos (if rdv_reg)
                raddr = pos_reg[AW-1:0];
                if (op_reg == ssmid_pkg::OP_QUERY)
                begin
                    ok_next = rdv_reg && rd_s == key_reg;
                end
                else if (op_reg == ssmid_pkg::OP_INSERT)
                begin
                    if (!(rdv_reg && rd_s == key_reg))
                    begin
                        if (cnt_reg == CW'(CAPACITY))
                        begin
                            full_next = 1'b1;
                        end
                        else
                        begin
                            ok_next    = 1'b1;
                            carry_next = key_reg;
                        end
                    end
                end
                else if (rdv_reg && rd_s == key_reg)
                begin
                    ok_next = 1'b1;
                    // read pos+1 for first pull-down
                    raddr = AW'(pos_reg + CW'(1));
                end
            end
            ssmid_pkg::ST_SHIFT:
            begin
                if (op_reg == ssmid_pkg::OP_INSERT)
                begin
                    // write carry at pos, read pos+1; old value of pos rides on as carry
                    we         = 1'b1;
                    raddr      = AW'(pos_reg + CW'(1));
                    carry_next = signed'(rdata);
                    pos_next   = pos_reg + CW'(1);
                    if (pos_reg == cnt_reg)
                    begin
                        cnt_next = cnt_reg + CW'(1);
                    end
                end
                else
                begin
                    // rdata = entry pos+1; write it at pos
                    if (pos_reg + CW'(1) < cnt_reg)
                    begin
                        we    = 1'b1;
                        wdata = rdata;
                    end
                    raddr    = AW'(pos_reg + CW'(2));
                    pos_next = pos_reg + CW'(1);
                    if (pos_reg + CW'(1) >= cnt_reg)
                    begin
                        cnt_next = cnt_reg - CW'(1);
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // Result register: holds a word until taken, reloads in the same cycle
    always_comb
    begin
        out_valid_next = out_valid_reg && !res.ready;
        out_ok_next    = out_ok_reg;
        out_full_next  = out_full_reg;
        out_cnt_next   = out_cnt_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_ok_next    = ok_reg;
            out_full_next  = full_reg;
            out_cnt_next   = 9'(cnt_reg);
        end
    end

    assign res.valid       = out_valid_reg;
    assign res.success     = out_ok_reg;
    assign res.full_res    = out_full_reg;
    assign res.entry_count = out_cnt_reg;

    `SS_ASSERT_IMPL(a_no_overfill, clk, rst_n, 1'b1, cnt_reg <= CW'(CAPACITY),
        "count above capacity")
    `SS_ASSERT_IMPL(a_flags_excl, clk, rst_n, res.valid, !(res.success && res.full_res),
        "success and full together")
    `SS_ASSERT_NEXT(a_busy_noaccept, clk, rst_n, state_reg != ssmid_pkg::ST_IDLE,
        !(cmd.ready && state_reg != ssmid_pkg::ST_IDLE), "ready while busy")
    `SS_ASSERT_NEXT(a_res_hold, clk, rst_n, res.valid && !res.ready,
        res.valid && $stable(res.entry_count), "result dropped while stalled")
endmodule

/* src/ssmid_ram.sv */
// ----------------------------------------------------------------------------
// ssmid_ram
// Generic single-port-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ssmid_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
